FILE: sv/utrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utrr_pkg;

    // Operation codes carried in the input tuser
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_RX      = 3'd3;
    localparam logic [2:0] OP_TXC_ACK = 3'd4;

    // Register selects
    localparam logic [2:0] REG_STATUS_A = 3'd0;
    localparam logic [2:0] REG_CTRL_B   = 3'd1;
    localparam logic [2:0] REG_CTRL_C   = 3'd2;
    localparam logic [2:0] REG_BAUD_LO  = 3'd4;
    localparam logic [2:0] REG_BAUD_HI  = 3'd5;
    localparam logic [2:0] REG_DATA     = 3'd6;

    // Status A bits
    localparam int ST_RXC  = 7;
    localparam int ST_TXC  = 6;
    localparam int ST_UDRE = 5;
    localparam int ST_FE   = 4;
    localparam int ST_DOR  = 3;
    localparam int ST_UPE  = 2;
    localparam int ST_U2X  = 1;
    localparam int ST_MPCM = 0;

    // Control B bits
    localparam int CB_RXCIE = 7;
    localparam int CB_TXCIE = 6;
    localparam int CB_UDRIE = 5;
    localparam int CB_RXEN  = 4;
    localparam int CB_TXEN  = 3;
    localparam int CB_SZ2   = 2;

    // Control C bits
    localparam int CC_PAR   = 5;
    localparam int CC_STOP2 = 3;
    localparam int CC_SZ1   = 2;
    localparam int CC_SZ0   = 1;

    localparam logic [7:0] STATUS_A_RST = 8'h20;
    localparam logic [7:0] CTRL_C_RST   = 8'h06;
    localparam logic [7:0] UNMAPPED_RD  = 8'hFF;

    localparam int CNT_W  = 20;
    localparam int IN_W   = 48;
    localparam int OUT_W  = 24;

    typedef struct packed {
        logic [2:0]       operation;
        logic [2:0]       reg_select;
        logic [7:0]       write_data;
        logic [CNT_W-1:0] elapsed_cycles;
        logic [7:0]       rx_byte;
        logic             rx_frame_error;
        logic             rx_parity_error;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_rx_complete;
        logic       irq_data_empty;
        logic       irq_tx_complete;
    } t_result;

    // Core state seen by the top level checks
    typedef struct packed {
        logic [7:0] status_a;
        logic       tx_busy;
    } t_core_stat;

endpackage

`default_nettype wire

FILE: sv/utrr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module utrr_core
    import utrr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_step,
    input  t_item      i_item,
    output t_result    o_result,
    output t_core_stat o_stat
);

    logic [7:0]       r_status_a, n_status_a;
    logic [7:0]       r_ctrl_b, n_ctrl_b;
    logic [7:0]       r_ctrl_c, n_ctrl_c;
    logic [7:0]       r_baud_lo, n_baud_lo;
    logic [3:0]       r_baud_hi, n_baud_hi;
    logic [7:0]       r_rx_buf, n_rx_buf;
    logic [7:0]       r_tx_buf, n_tx_buf;
    logic [CNT_W-1:0] r_tx_cnt, n_tx_cnt;

    logic [2:0]       size_code;
    logic [3:0]       data_bits;
    logic [3:0]       frame_bits;
    logic [12:0]      div_plus1;
    logic [16:0]      bits_x_div;
    logic [CNT_W-1:0] frame_len;

    // Frame length: bits per frame times cycles per bit
    always_comb begin
        size_code = {r_ctrl_b[CB_SZ2], r_ctrl_c[CC_SZ1], r_ctrl_c[CC_SZ0]};
        priority if (!size_code[2]) begin
            data_bits = 4'd5 + {2'b00, size_code[1:0]};
        end else if (size_code == 3'd7) begin
            data_bits = 4'd9;
        end else begin
            data_bits = 4'd8;
        end
        frame_bits = 4'd1 + data_bits + {3'b000, r_ctrl_c[CC_PAR]}
                   + (r_ctrl_c[CC_STOP2] ? 4'd2 : 4'd1);
        div_plus1  = {1'b0, r_baud_hi, r_baud_lo} + 13'd1;
        bits_x_div = {13'd0, frame_bits} * {4'd0, div_plus1};
        frame_len  = r_status_a[ST_U2X] ? {bits_x_div, 3'b000}
                                        : {bits_x_div[15:0], 4'b0000};
    end

    // Next state and result for the item in the input register
    always_comb begin
        n_status_a = r_status_a;
        n_ctrl_b   = r_ctrl_b;
        n_ctrl_c   = r_ctrl_c;
        n_baud_lo  = r_baud_lo;
        n_baud_hi  = r_baud_hi;
        n_rx_buf   = r_rx_buf;
        n_tx_buf   = r_tx_buf;
        n_tx_cnt   = r_tx_cnt;
        o_result   = '0;

        unique case (i_item.operation)
            OP_READ: begin
                unique case (i_item.reg_select)
                    REG_STATUS_A: o_result.read_data = r_status_a;
                    REG_CTRL_B:   o_result.read_data = r_ctrl_b;
                    REG_CTRL_C:   o_result.read_data = r_ctrl_c;
                    REG_BAUD_LO:  o_result.read_data = r_baud_lo;
                    REG_BAUD_HI:  o_result.read_data = {4'h0, r_baud_hi};
                    REG_DATA: begin
                        o_result.read_data  = r_rx_buf;
                        n_status_a[ST_RXC]  = 1'b0;
                        n_status_a[ST_FE]   = 1'b0;
                        n_status_a[ST_DOR]  = 1'b0;
                        n_status_a[ST_UPE]  = 1'b0;
                    end
                    default: o_result.read_data = UNMAPPED_RD;
                endcase
            end
            OP_WRITE: begin
                unique case (i_item.reg_select)
                    REG_STATUS_A: begin
                        if (i_item.write_data[ST_TXC]) begin
                            n_status_a[ST_TXC] = 1'b0;
                        end
                        n_status_a[ST_U2X]  = i_item.write_data[ST_U2X];
                        n_status_a[ST_MPCM] = i_item.write_data[ST_MPCM];
                    end
                    REG_CTRL_B:  n_ctrl_b  = i_item.write_data;
                    REG_CTRL_C:  n_ctrl_c  = i_item.write_data;
                    REG_BAUD_LO: n_baud_lo = i_item.write_data;
                    REG_BAUD_HI: n_baud_hi = i_item.write_data[3:0];
                    REG_DATA: begin
                        // Load and (re)start a frame only with the transmitter on
                        if (r_ctrl_b[CB_TXEN]) begin
                            n_tx_buf            = i_item.write_data;
                            n_status_a[ST_UDRE] = 1'b0;
                            n_tx_cnt            = frame_len;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_TICK: begin
                // Count the frame down; finish it when the elapsed cycles cover it
                if (r_tx_cnt != '0) begin
                    if (i_item.elapsed_cycles >= r_tx_cnt) begin
                        n_tx_cnt            = '0;
                        o_result.tx_valid   = 1'b1;
                        o_result.tx_byte    = r_tx_buf;
                        n_status_a[ST_UDRE] = 1'b1;
                        n_status_a[ST_TXC]  = 1'b1;
                    end else begin
                        n_tx_cnt = r_tx_cnt - i_item.elapsed_cycles;
                    end
                end
            end
            OP_RX: begin
                // Flag overrun while an unread byte is held
                if (r_status_a[ST_RXC]) begin
                    n_status_a[ST_DOR] = 1'b1;
                end else begin
                    n_rx_buf           = i_item.rx_byte;
                    n_status_a[ST_RXC] = 1'b1;
                    n_status_a[ST_FE]  = i_item.rx_frame_error;
                    n_status_a[ST_UPE] = i_item.rx_parity_error;
                end
            end
            OP_TXC_ACK: n_status_a[ST_TXC] = 1'b0;
            default: begin
            end
        endcase

        // Interrupt levels from the updated state
        o_result.irq_rx_complete = n_ctrl_b[CB_RXCIE] & n_ctrl_b[CB_RXEN]
                                 & n_status_a[ST_RXC];
        o_result.irq_data_empty  = n_ctrl_b[CB_UDRIE] & n_ctrl_b[CB_TXEN]
                                 & n_status_a[ST_UDRE];
        o_result.irq_tx_complete = n_ctrl_b[CB_TXCIE] & n_ctrl_b[CB_TXEN]
                                 & n_status_a[ST_TXC];
    end

    // Commit state when the item advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_a <= STATUS_A_RST;
            r_ctrl_b   <= '0;
            r_ctrl_c   <= CTRL_C_RST;
            r_baud_lo  <= '0;
            r_baud_hi  <= '0;
            r_rx_buf   <= '0;
            r_tx_buf   <= '0;
            r_tx_cnt   <= '0;
        end else if (i_step) begin
            r_status_a <= n_status_a;
            r_ctrl_b   <= n_ctrl_b;
            r_ctrl_c   <= n_ctrl_c;
            r_baud_lo  <= n_baud_lo;
            r_baud_hi  <= n_baud_hi;
            r_rx_buf   <= n_rx_buf;
            r_tx_buf   <= n_tx_buf;
            r_tx_cnt   <= n_tx_cnt;
        end
    end

    assign o_stat.status_a = r_status_a;
    assign o_stat.tx_busy  = (r_tx_cnt != '0);

endmodule

`default_nettype wire

FILE: sv/uart_transmit_receive_registers_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// UART control/status register unit with a timed transmitter. Each input item is a bus
// read, a bus write, a tick with the elapsed CPU clock count, a received byte or a tx-complete vector
// acknowledge, and produces exactly one result item carrying read data, a finished tx byte
// and the three interrupt request levels after the item. One item is taken every cycle
// while the output is not stalled; an accepted item sits in the input register, moves
// to the result register and is presented on the output from there. The step between
// the two registers holds the frame-length multiply (frame bits times divisor plus one)
// and the 20-bit countdown compare and subtract. A stalled output holds the result
// register and then the input register; no item is dropped.

module uart_transmit_receive_registers_unit
    import utrr_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] reg_select, [10:3] write_data, [30:11] elapsed_cycles, [38:31] rx_byte,
    // [39] rx_frame_error, [40] rx_parity_error, [47:41] zero
    input  wire [IN_W-1:0]   s_axis_tdata,
    // [2:0] operation
    input  wire [2:0]        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    // [7:0] read_data, [8] tx_valid, [16:9] tx_byte, [17] irq_rx_complete,
    // [18] irq_data_empty, [19] irq_tx_complete, [23:20] zero
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_out;
    logic       step;
    t_result    result;
    t_core_stat stat;

    // Advance when the result register is free or being emptied
    assign step          = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.operation       <= s_axis_tuser;
            r_in.reg_select      <= s_axis_tdata[2:0];
            r_in.write_data      <= s_axis_tdata[10:3];
            r_in.elapsed_cycles  <= s_axis_tdata[30:11];
            r_in.rx_byte         <= s_axis_tdata[38:31];
            r_in.rx_frame_error  <= s_axis_tdata[39];
            r_in.rx_parity_error <= s_axis_tdata[40];
        end
    end

    utrr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (result),
        .o_stat   (stat)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_out.irq_tx_complete, r_out.irq_data_empty,
                            r_out.irq_rx_complete, r_out.tx_byte, r_out.tx_valid,
                            r_out.read_data};

    // Data-empty is set exactly when no frame is counting down
    a_udre_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.status_a[ST_UDRE] == ~stat.tx_busy)
        else $error("data-empty flag disagrees with transmitter countdown");

    // A finished frame leaves data-empty and tx-complete set
    a_tx_done_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && result.tx_valid |=> stat.status_a[ST_UDRE] && stat.status_a[ST_TXC])
        else $error("finished frame did not set status flags");

    // Only ticks finish frames
    a_tx_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && result.tx_valid |-> r_in.operation == OP_TICK)
        else $error("tx byte emitted by a non-tick item");

    // A stalled result blocks the step
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !step)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
